/* hw/rtl/lcdfs_pkg.sv */
// lcdfs_pkg: types, codes and constants shared by the LCD line frame sender.
// No dependencies; used by every module of the block except lcdfs_ram.
`timescale 1ns / 1ps
`default_nettype none

package lcdfs_pkg;

  // Default geometry of the character store
  localparam int LineCharsDef = 16;
  localparam int RowsDef      = 2;

  // Frame layout: header, line code, characters, checksum
  localparam int HeadLen = 4;
  localparam int ExtraLen = HeadLen + 2;

  localparam logic [7:0] Space     = 8'h20;
  localparam logic [7:0] Backlight = 8'h02;

  // Item function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_SEND  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic       row;
    logic [3:0] column;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } result_t;

  // Which part of the frame the current byte comes from
  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_LINE,
    SEL_CHAR,
    SEL_SUM
  } sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       wr;        // store the item's character
    logic       clr;       // clear the store to spaces
    logic       load;      // latch the row for a new frame
    logic       emit;      // produce one frame byte
    sel_e       sel;
    logic [1:0] head_idx;
    logic       rd_next;   // step the character read pointer
    logic       last;      // checksum byte, frame ends
  } cmd_t;

  function automatic logic [7:0] head_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hAA;
      2'd1:    b = 8'h55;
      2'd2:    b = 8'h1E;
      default: b = 8'h12;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lcdfs_ram.sv */
// lcdfs_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lcdfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/lcdfs_ctrl.sv */
// lcdfs_ctrl: sequencer for the LCD line frame sender; decodes items and
// steps through the frame. Depends on lcdfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdfs_ctrl #(
  parameter int LineChars = lcdfs_pkg::LineCharsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [1:0]        func_i,
  output      logic              busy_o,
  output      lcdfs_pkg::cmd_t   cmd_o
);

  localparam int FrameLen = LineChars + lcdfs_pkg::ExtraLen;
  localparam int CW       = $clog2(FrameLen);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;

  assign busy_o = (state_q == ST_SEND);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.sel      = lcdfs_pkg::SEL_HEAD;
    cmd_o.head_idx = cnt_q[1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            lcdfs_pkg::FUNC_WRITE: cmd_o.wr = 1'b1;
            lcdfs_pkg::FUNC_CLEAR: cmd_o.clr = 1'b1;
            lcdfs_pkg::FUNC_SEND: begin
              cmd_o.load = 1'b1;
              state_d    = ST_SEND;
              cnt_d      = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SEND: begin
        cmd_o.emit = 1'b1;
        if (cnt_q < CW'(lcdfs_pkg::HeadLen)) begin
          cmd_o.sel = lcdfs_pkg::SEL_HEAD;
        end else if (cnt_q == CW'(lcdfs_pkg::HeadLen)) begin
          cmd_o.sel = lcdfs_pkg::SEL_LINE;
        end else if (cnt_q == CW'(FrameLen - 1)) begin
          cmd_o.sel = lcdfs_pkg::SEL_SUM;
        end else begin
          cmd_o.sel = lcdfs_pkg::SEL_CHAR;
        end
        // character i is read in slot HeadLen + i, the slot before the one that sends it
        cmd_o.rd_next = (cnt_q >= CW'(lcdfs_pkg::HeadLen)) &&
                        (cnt_q < CW'(lcdfs_pkg::HeadLen + LineChars));
        if (cnt_q == CW'(FrameLen - 1)) begin
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lcdfs_datapath.sv */
// lcdfs_datapath: character store, NUL blanking, checksum and output register.
// Depends on lcdfs_pkg and lcdfs_ram.
`timescale 1ns / 1ps
`default_nettype none

module lcdfs_datapath #(
  parameter int LineChars = lcdfs_pkg::LineCharsDef,
  parameter int Rows      = lcdfs_pkg::RowsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lcdfs_pkg::cmd_t    cmd_i,
  input  wire lcdfs_pkg::item_t   item_i,
  input  wire logic               backlight_we_i,
  input  wire logic               backlight_i,
  output      logic               result_valid_o,
  output      lcdfs_pkg::result_t result_o
);

  localparam int Depth = Rows * LineChars;
  localparam int AW    = $clog2(Depth);
  localparam int RW    = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int PW    = $clog2(LineChars);

  logic             backlight_q;
  logic [RW-1:0]    next_row_q;
  logic [RW-1:0]    row_q;
  logic [PW-1:0]    ptr_q;
  logic [Depth-1:0] valid_q;
  logic             rd_valid_q;
  logic [7:0]       fill_q;
  logic [7:0]       sum_q;
  logic             ended_q;
  logic             res_valid_q;
  lcdfs_pkg::result_t res_q;

  logic          wr_ok;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [7:0]    raw;
  logic [7:0]    ch;
  logic [7:0]    line_code;

  assign wr_ok = cmd_i.wr && (32'(item_i.row) < Rows) && (32'(item_i.column) < LineChars);
  assign waddr = AW'(item_i.row) * AW'(LineChars) + AW'(item_i.column);
  assign raddr = AW'(row_q) * AW'(LineChars) + AW'(ptr_q);

  lcdfs_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (waddr),
    .wdata_i (item_i.char_code),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // entries not written since reset or the last clear read as the fill byte
  assign raw       = rd_valid_q ? rdata : fill_q;
  assign ch        = (ended_q || (raw == 8'd0)) ? lcdfs_pkg::Space : raw;
  assign line_code = 8'(row_q) + (backlight_q ? lcdfs_pkg::Backlight : 8'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlight_q <= 1'b1;
      next_row_q  <= '0;
      valid_q     <= '0;
      fill_q      <= 8'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (backlight_we_i) begin
        backlight_q <= backlight_i;
      end
      if (cmd_i.clr) begin
        valid_q <= '0;
        fill_q  <= lcdfs_pkg::Space;
      end else if (wr_ok) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.last) begin
        next_row_q <= (32'(row_q) == Rows - 1) ? '0 : row_q + RW'(1);
      end
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_valid_q <= valid_q[raddr];
    if (cmd_i.load) begin
      row_q   <= next_row_q;
      ptr_q   <= '0;
      ended_q <= 1'b0;
    end else if (cmd_i.rd_next) begin
      ptr_q <= ptr_q + PW'(1);
    end
    if (cmd_i.emit) begin
      res_q.last <= cmd_i.last;
      case (cmd_i.sel)
        lcdfs_pkg::SEL_HEAD: res_q.tx_byte <= lcdfs_pkg::head_byte(cmd_i.head_idx);
        lcdfs_pkg::SEL_LINE: begin
          res_q.tx_byte <= line_code;
          sum_q         <= line_code;
        end
        lcdfs_pkg::SEL_CHAR: begin
          res_q.tx_byte <= ch;
          sum_q         <= sum_q + ch;
          ended_q       <= ended_q || (raw == 8'd0);
        end
        lcdfs_pkg::SEL_SUM: res_q.tx_byte <= 8'd0 - sum_q;
        default: res_q.tx_byte <= 8'd0;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

/* hw/rtl/lcd_line_frame_sender.sv */
// lcd_line_frame_sender: top level of the serial LCD line frame sender.
// Depends on lcdfs_pkg, lcdfs_ctrl, lcdfs_datapath and lcdfs_ram.
//
//   Channel   | Signals                          | Transfer when
//   ----------+----------------------------------+------------------------------
//   item in   | start_i, item_i, busy_o          | start_i high and busy_o low
//   result out| result_valid_o, result_o         | every cycle result_valid_o is high
//   config    | backlight_we_i, backlight_i      | backlight_we_i high
//
// A write or clear item gives no result; busy_o stays low.
// A send item holds busy_o while it sends its frame of LineChars + 6 bytes (22 at the defaults), the
// frame sequencer emitting one byte per cycle; each byte is registered and appears in the cycle after.
// The store has a registered read port, so each character is fetched in the slot
// before the byte that carries it. Clear resets all per-entry valid bits together,
// so no clearing pass is needed after reset or clear.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module lcd_line_frame_sender #(
  parameter int LineChars = lcdfs_pkg::LineCharsDef,  // 8 .. 16
  parameter int Rows      = lcdfs_pkg::RowsDef        // 1 .. 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item channel
  input  wire logic               start_i,
  input  wire lcdfs_pkg::item_t   item_i,
  output      logic               busy_o,
  // result channel
  output      logic               result_valid_o,
  output      lcdfs_pkg::result_t result_o,
  // backlight register
  input  wire logic               backlight_we_i,
  input  wire logic               backlight_i
);

  lcdfs_pkg::cmd_t cmd;

  // sequencer: decodes the item and walks header, line code, text, checksum
  lcdfs_ctrl #(
    .LineChars (LineChars)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (item_i.func),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // store, text blanking after the first NUL, running checksum, output register
  lcdfs_datapath #(
    .LineChars (LineChars),
    .Rows      (Rows)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .backlight_we_i (backlight_we_i),
    .backlight_i    (backlight_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire
